// ----- rtl/ialu_pkg.sv -----
// Shared constants for the iterative integer ALU: word width, operation codes
// and the magnitude helper. No dependencies.
`default_nettype none

package ialu_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned SIGN_BIT = WORD_W - 1;
	localparam int unsigned CNT_W    = $clog2(WORD_W);

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_POW = 3'd4;

	typedef logic [WORD_W-1:0] word_t;

	// Magnitude of a two's complement word; the most negative value maps to 2^31 unsigned.
	function automatic word_t mag(input word_t v);
		mag = v[SIGN_BIT] ? (word_t'(0) - v) : v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_alu_iterative_mul_div_pow_top.sv -----
// Top level of the iterative integer ALU: control sequencer, bit-serial adder,
// restoring divider and output register. Depends on ialu_pkg and ialu_mul.
`default_nettype none

// Usage
// The input channel (in_valid, in_ready) carries one beat of mode, operand_a and
// operand_b; the output channel (out_valid, out_ready) carries one beat of
// result and divide_by_zero for every input beat, in order.
// The block works on one beat at a time. in_ready is high while the sequencer
// is idle, also when a finished result still waits in the output register.
// How each operation runs from acceptance until the result is in the output register:
//   add, subtract: one sum bit per cycle through the serial adder.
//   multiply: the shift-add multiplier runs until no set bits of operand_b remain.
//   divide: one quotient bit per cycle; a zero divisor goes straight to the finish state.
//   power: one pass for each exponent bit up to the highest set bit; in each pass two
//   shift-add multipliers run the multiply and the squaring side by side. A negative
//   exponent goes straight to the finish state.
//   unused modes: straight to the finish state.
// The next beat can be taken in the cycle after a result enters the output register.
// If the receiver stalls, the finished result waits in the sequencer until the
// output register frees, and no new beat is taken meanwhile.
// Reset clears the sequencer, the output valid flag and the data registers; only the first two need it.
module integer_alu_iterative_mul_div_pow_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [2:0]            mode,
	input  wire ialu_pkg::word_t  operand_a,
	input  wire ialu_pkg::word_t  operand_b,
	output logic                  out_valid,
	input  wire                   out_ready,
	output ialu_pkg::word_t       result,
	output logic                  divide_by_zero
);
	import ialu_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_MWAIT,
		S_DIV,
		S_POW,
		S_PWAIT,
		S_FIN
	} state_t;

	state_t           state_q;
	word_t            a_q;       // addend, dividend/quotient, or power square
	word_t            b_q;       // addend, divisor, or remaining exponent
	word_t            r_q;       // sum, remainder, power product, final result
	logic             carry_q;
	logic             neg_q;
	logic             dz_q;
	logic [CNT_W-1:0] cnt_q;

	logic             out_valid_q;
	word_t            result_q;
	logic             dz_out_q;

	logic             accept;
	logic             out_free;

	// Serial adder slice.
	logic             sum_bit;
	logic             carry_next;

	// Restoring divider step.
	logic [WORD_W:0]  rem_sh;
	logic [WORD_W:0]  diff;
	logic             ge;
	word_t            q_next;
	word_t            r_next;

	// Multiplier hookup.
	logic             pow_go;
	logic             mul0_start;
	logic             mul1_start;
	word_t            mul0_x;
	word_t            mul0_y;
	word_t            mul0_p;
	word_t            mul1_p;
	logic             mul0_busy;
	logic             mul1_busy;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign sum_bit    = a_q[0] ^ b_q[0] ^ carry_q;
	assign carry_next = (a_q[0] & b_q[0]) | (carry_q & (a_q[0] ^ b_q[0]));

	assign rem_sh = {r_q, a_q[SIGN_BIT]};
	assign diff   = rem_sh - {1'b0, b_q};
	assign ge     = !diff[WORD_W];
	assign q_next = {a_q[WORD_W-2:0], ge};
	assign r_next = ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];

	// One exponent bit per pass: acc*sq on one multiplier, sq*sq on the other.
	assign pow_go     = (state_q == S_POW) && (b_q != '0);
	assign mul0_start = (accept && (mode == MODE_MUL)) || pow_go;
	assign mul1_start = pow_go;
	assign mul0_x     = (state_q == S_IDLE) ? operand_a : r_q;
	assign mul0_y     = (state_q == S_IDLE) ? operand_b : a_q;

	ialu_mul u_mul0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul0_start),
		.x       (mul0_x),
		.y       (mul0_y),
		.product (mul0_p),
		.busy    (mul0_busy)
	);

	ialu_mul u_mul1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul1_start),
		.x       (a_q),
		.y       (a_q),
		.product (mul1_p),
		.busy    (mul1_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			r_q         <= '0;
			carry_q     <= 1'b0;
			neg_q       <= 1'b0;
			dz_q        <= 1'b0;
			cnt_q       <= '0;
			result_q    <= '0;
			dz_out_q    <= 1'b0;
		end else begin
			// The finish state reloads the register itself when it frees.
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						dz_q  <= 1'b0;
						cnt_q <= '0;
						unique case (mode)
							MODE_ADD, MODE_SUB: begin
								a_q     <= operand_a;
								b_q     <= (mode == MODE_SUB) ? ~operand_b : operand_b;
								carry_q <= (mode == MODE_SUB);
								state_q <= S_ADD;
							end
							MODE_MUL: begin
								state_q <= S_MWAIT;
							end
							MODE_DIV: begin
								if (operand_b == '0) begin
									r_q     <= '0;
									dz_q    <= 1'b1;
									state_q <= S_FIN;
								end else begin
									neg_q   <= operand_a[SIGN_BIT] ^ operand_b[SIGN_BIT];
									a_q     <= mag(operand_a);
									b_q     <= mag(operand_b);
									r_q     <= '0;
									state_q <= S_DIV;
								end
							end
							MODE_POW: begin
								if (operand_b[SIGN_BIT]) begin
									r_q     <= word_t'(1);
									state_q <= S_FIN;
								end else begin
									r_q     <= word_t'(1);
									a_q     <= operand_a;
									b_q     <= operand_b;
									state_q <= S_POW;
								end
							end
							default: begin
								r_q     <= '0;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ADD: begin
					a_q     <= {1'b0, a_q[WORD_W-1:1]};
					b_q     <= {1'b0, b_q[WORD_W-1:1]};
					r_q     <= {sum_bit, r_q[WORD_W-1:1]};
					carry_q <= carry_next;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_MWAIT: begin
					if (!mul0_busy) begin
						r_q     <= mul0_p;
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					a_q   <= q_next;
					r_q   <= r_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						r_q     <= neg_q ? (word_t'(0) - q_next) : q_next;
						state_q <= S_FIN;
					end
				end
				S_POW: begin
					// The product register already holds the answer once the
					// exponent runs out.
					state_q <= (b_q == '0) ? S_FIN : S_PWAIT;
				end
				S_PWAIT: begin
					if (!mul0_busy && !mul1_busy) begin
						if (b_q[0]) begin
							r_q <= mul0_p;
						end
						a_q     <= mul1_p;
						b_q     <= {1'b0, b_q[WORD_W-1:1]};
						state_q <= S_POW;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						result_q    <= r_q;
						dz_out_q    <= dz_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign result         = result_q;
	assign divide_by_zero = dz_out_q;

	// A divide by zero always reports a zero result.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result == '0)
		else $error("divide_by_zero set with a nonzero result");

	// Only one beat is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input accepted while a beat is still in work");

	// The divider never runs with a zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> b_q != '0)
		else $error("divider running with a zero divisor");

	// The power loop only ever sees a nonnegative exponent.
	a_pow_exp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POW || state_q == S_PWAIT) |-> !b_q[SIGN_BIT])
		else $error("power loop with a negative exponent");

	// A result is only loaded into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result) && $stable(divide_by_zero))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- rtl/ialu_mul.sv -----
// Shift-add multiplier: one multiplier bit per cycle, low word of the product.
// Depends on ialu_pkg.
`default_nettype none

module ialu_mul (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire ialu_pkg::word_t  x,
	input  wire ialu_pkg::word_t  y,
	output ialu_pkg::word_t       product,
	output logic                  busy
);
	import ialu_pkg::*;

	word_t acc_q;
	word_t mcand_q;
	word_t mplier_q;
	logic  busy_q;

	// The run ends as soon as no set multiplier bits remain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (mplier_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= x;
			mplier_q <= y;
		end else if (busy_q && (mplier_q != '0)) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[WORD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[WORD_W-1:1]};
		end
	end

	assign product = acc_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire
